// File: sv/lfu_pkg.sv
// Shared constants, types and scan carrier for the LFU cache.
`default_nettype none
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int VALUE_BITS = 32;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int USES_W  = 32;
	localparam int STAMP_W = 48;
	localparam int CAP_W   = 5;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic             FUNC_GET  = 1'b0;
	localparam logic             FUNC_PUT  = 1'b1;

	// Running result of the scan, handed from cell to cell.
	typedef struct packed {
		logic                  match;
		logic [IDX_W-1:0]      match_idx;
		logic [VALUE_BITS-1:0] match_val;
		logic                  best_vld;
		logic [IDX_W-1:0]      best_idx;
		logic [KEY_W-1:0]      best_key;
		logic [USES_W-1:0]     best_uses;
		logic [STAMP_W-1:0]    best_stamp;
		logic                  free_vld;
		logic [IDX_W-1:0]      free_idx;
	} scan_t;

	// Write command broadcast to all cells during the update cycle.
	typedef struct packed {
		logic                  wr;
		logic                  fresh;
		logic                  put;
		logic [IDX_W-1:0]      idx;
		logic [KEY_W-1:0]      key;
		logic [VALUE_BITS-1:0] value;
		logic [STAMP_W-1:0]    stamp;
	} cmd_t;

endpackage
`default_nettype wire

// File: sv/lfu_cache_replacement_top.sv
// Top level of the LFU key-value cache with least-recently-used tie break.
// Sequence: an accepted item ripples down the registered cell chain (ST_SCAN), is
//   applied in ST_UPDATE, and waits in ST_DONE until the output register is free.
// The cell chain serves one item at a time; in_ready is high only in ST_IDLE.
// Reset: arst_n clears all entry valid bits, the access clock and the live count at once,
//   and sets capacity to 16; no clearing pass is needed.
`default_nettype none
module lfu_cache_replacement_top import lfu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [KEY_W-1:0]  key,
	input  logic [DATA_W-1:0] value,
	// response channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [DATA_W-1:0] read_value,
	output logic              evicted,
	output logic [KEY_W-1:0]  evicted_key
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [CAP_W-1:0]      capacity_q;
	logic [CNT_W-1:0]      live_q;
	logic [STAMP_W-1:0]    clock_q;
	logic [CNT_W-1:0]      cap_eff;

	// item held for the whole scan
	logic                  func_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] val_q;

	// result held until the output register frees up
	logic                  res_hit_q;
	logic [DATA_W-1:0]     res_rd_q;
	logic                  res_ev_q;
	logic [KEY_W-1:0]      res_evk_q;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [DATA_W-1:0]     out_rd_q;
	logic                  out_ev_q;
	logic [KEY_W-1:0]      out_evk_q;

	scan_t                 chain [ENTRIES+1];
	scan_t                 tail;
	cmd_t                  cmd;
	logic                  u_hit;
	logic [DATA_W-1:0]     u_rd;
	logic                  u_ev;
	logic [KEY_W-1:0]      u_evk;
	logic                  u_alloc;
	logic                  in_acc;
	logic                  out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Clamp capacity to the number of physical entries.
	assign cap_eff = (32'(capacity_q) > 32'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(capacity_q);

	// The head of the chain sees an empty search; each cell adds its entry
	// through its own register, so the tail settles once the key has passed every cell.
	assign chain[0] = '0;
	assign tail     = chain[ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (IDX_W'(i)),
			.probe_key (key_q),
			.cmd       (cmd),
			.scan_in   (chain[i]),
			.scan_out  (chain[i+1])
		);
	end

	// Decide the update from the scan tail: touch a hit, replace the victim,
	// or fill a free slot.
	always_comb begin
		cmd     = '0;
		u_hit   = 1'b0;
		u_rd    = '0;
		u_ev    = 1'b0;
		u_evk   = '0;
		u_alloc = 1'b0;
		if (state_q == ST_UPDATE && cap_eff != '0) begin
			if (tail.match) begin
				u_hit     = 1'b1;
				cmd.wr    = 1'b1;
				cmd.idx   = tail.match_idx;
				cmd.put   = (func_q == FUNC_PUT);
				if (func_q == FUNC_GET) begin
					u_rd = DATA_W'(tail.match_val);
				end
			end else if (func_q == FUNC_PUT) begin
				if (live_q >= cap_eff) begin
					if (tail.best_vld) begin
						cmd.wr    = 1'b1;
						cmd.fresh = 1'b1;
						cmd.put   = 1'b1;
						cmd.idx   = tail.best_idx;
						u_ev      = 1'b1;
						u_evk     = tail.best_key;
					end
				end else if (tail.free_vld) begin
					cmd.wr    = 1'b1;
					cmd.fresh = 1'b1;
					cmd.put   = 1'b1;
					cmd.idx   = tail.free_idx;
					u_alloc   = 1'b1;
				end
			end
		end
		cmd.key   = key_q;
		cmd.value = val_q;
		cmd.stamp = clock_q;
	end

	// Control: sequencer, capacity, live count, access clock, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			capacity_q  <= CAP_RESET;
			live_q      <= '0;
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance until the tail of the chain holds this key's result
					if (cnt_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_UPDATE;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_UPDATE: begin
					if (cmd.wr) begin
						clock_q <= clock_q + STAMP_W'(1);
					end
					if (u_alloc) begin
						live_q <= live_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: captured item, pending result, output register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			key_q  <= key;
			val_q  <= VALUE_BITS'(value);
		end
		if (state_q == ST_UPDATE) begin
			res_hit_q <= u_hit;
			res_rd_q  <= u_rd;
			res_ev_q  <= u_ev;
			res_evk_q <= u_evk;
		end
		if (state_q == ST_DONE && out_free) begin
			out_hit_q <= res_hit_q;
			out_rd_q  <= res_rd_q;
			out_ev_q  <= res_ev_q;
			out_evk_q <= res_evk_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign read_value  = out_rd_q;
	assign evicted     = out_ev_q;
	assign evicted_key = out_evk_q;

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(ENTRIES))
		else $error("live count exceeds entry count");

	a_put_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && cap_eff != '0 && func_q == FUNC_PUT) |-> cmd.wr)
		else $error("put with nonzero capacity issued no write");

	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && cmd.wr) |=> (clock_q == $past(clock_q) + STAMP_W'(1)))
		else $error("access clock did not advance on a use");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ev_q) |-> !out_hit_q)
		else $error("eviction reported on a hit");

endmodule
`default_nettype wire

// File: sv/lfu_cell.sv
// One cache entry with its stage of the match and victim scan chain.
`default_nettype none
module lfu_cell import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [KEY_W-1:0] probe_key,
	input  cmd_t             cmd,
	input  scan_t            scan_in,
	output scan_t            scan_out
);

	logic                  valid_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [USES_W-1:0]     uses_q;
	logic [STAMP_W-1:0]    stamp_q;
	scan_t                 scan_q;
	scan_t                 scan_d;
	logic                  sel;

	assign sel = cmd.wr && (cmd.idx == cell_idx);

	// Fold this entry into the running match, victim and free-slot search.
	always_comb begin
		scan_d = scan_in;
		if (!scan_in.match && valid_q && key_q == probe_key) begin
			scan_d.match     = 1'b1;
			scan_d.match_idx = cell_idx;
			scan_d.match_val = value_q;
		end
		if (valid_q && (!scan_in.best_vld || uses_q < scan_in.best_uses ||
				(uses_q == scan_in.best_uses && stamp_q < scan_in.best_stamp))) begin
			scan_d.best_vld   = 1'b1;
			scan_d.best_idx   = cell_idx;
			scan_d.best_key   = key_q;
			scan_d.best_uses  = uses_q;
			scan_d.best_stamp = stamp_q;
		end
		if (!scan_in.free_vld && !valid_q) begin
			scan_d.free_vld = 1'b1;
			scan_d.free_idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.fresh) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		if (sel) begin
			stamp_q <= cmd.stamp;
			if (cmd.put) begin
				value_q <= cmd.value;
			end
			if (cmd.fresh) begin
				key_q  <= cmd.key;
				uses_q <= USES_W'(1);
			end else if (uses_q != '1) begin
				uses_q <= uses_q + USES_W'(1);
			end
		end
	end

	assign scan_out = scan_q;

endmodule
`default_nettype wire
